// File: hw/rtl/itl_pkg.sv
package itl_pkg;

    // table geometry
    localparam int ENTRIES = 1024;
    localparam int DW      = 32;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW      = $clog2(ENTRIES + 1);
    localparam int STEPS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic          mode;
        logic [DW-1:0] entry_boundary;
        logic [DW-1:0] entry_value;
        logic          load_start;
        logic [DW-1:0] position;
    } t_in;

    typedef struct packed {
        logic [DW-1:0] mapped_value;
        logic          beyond_end;
        logic          load_overflow;
    } t_out;

    // search window handed from one cell to the next
    typedef struct packed {
        logic          act;
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
    } t_link;

    // final window low edge reported by the cell that ends the search
    typedef struct packed {
        logic          done;
        logic [CW-1:0] lo;
    } t_done;

    function automatic logic [CW-1:0] itl_mid(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
        logic [CW:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[CW:1];
    endfunction

endpackage

// File: hw/rtl/itl_ram.sv
module itl_ram
    import itl_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/itl_cell.sv
module itl_cell
    import itl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_link         i_link,
    input  logic [DW-1:0] i_bnd,
    input  logic [DW-1:0] i_pos,
    output t_link         o_link,
    output t_done         o_done
);

    logic          r_act;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;

    logic [CW-1:0] w_mid;
    logic [CW-1:0] n_lo;
    logic [CW-1:0] n_hi;
    logic          w_lt;
    logic          w_eq;
    logic          w_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= i_link.act;
        end
        r_lo <= i_link.lo;
        r_hi <= i_link.hi;
    end

    // boundary at the window midpoint arrives from the RAM in this cycle
    always_comb begin
        w_mid = itl_mid(r_lo, r_hi);
        w_lt  = i_pos < i_bnd;
        w_eq  = i_pos == i_bnd;
        n_lo  = w_lt ? r_lo  : w_mid;
        n_hi  = w_lt ? w_mid : r_hi;
        // stop on an exact hit or once the window holds a single entry
        w_fin = w_eq || (({1'b0, n_lo} + {{CW{1'b0}}, 1'b1}) >= {1'b0, n_hi});
    end

    assign o_link = '{act: r_act && !w_fin, lo: n_lo, hi: n_hi};
    assign o_done = '{done: r_act && w_fin, lo: n_lo};

endmodule

// File: hw/rtl/interval_table_lookup_top.sv
// Channel | Direction | Handshake               | Beat payload
// in      | input     | i_in_valid / o_in_ready  | t_in  (load entry or query position)
// out     | output    | o_out_valid / i_out_ready| t_out (mapped value and flags)
//
// A load beat writes both tables at the fill pointer (at entry zero when
// load_start restarts the fill). A query first reads and checks the last
// boundary, then passes through the cells of the search chain, and ends with
// one value read that also loads the output register. The next beat is taken
// only once the query is through: the single read port of the boundary RAM
// is used by each cell in turn.
// Reset is synchronous, active low; it empties the table (count to zero) and
// clears the output valid. The tables need no clearing pass.
// A result that cannot enter the full output register waits in a holding
// register; the input side stays stalled until it moves on.
module interval_table_lookup_top
    import itl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_VALUE  = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [DW-1:0] r_pos;
    t_out          r_res, n_res;
    t_out          r_out;
    logic          r_out_valid;

    logic          w_accept;
    logic          w_slot_free;
    logic          w_produce;
    t_out          w_res;
    logic          w_load_out;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_baddr;
    logic [AW-1:0] w_vaddr;
    logic [DW-1:0] w_bnd;
    logic [DW-1:0] w_val;

    t_link         w_head;
    t_link         w_link [STEPS+1];
    t_done         w_done [STEPS];
    logic          w_fin_any;
    logic [CW-1:0] w_fin_lo;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Table memories: written by load beats, read by the search.
    itl_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_bnd_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.entry_boundary),
        .i_raddr (w_baddr),
        .o_rdata (w_bnd)
    );

    itl_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.entry_value),
        .i_raddr (w_vaddr),
        .o_rdata (w_val)
    );

    // Feed the head of the chain with the window opened by the control FSM.
    assign w_link[0] = w_head;

    // Search chain: each cell halves the window once and hands it on.
    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        itl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (w_link[k]),
            .i_bnd   (w_bnd),
            .i_pos   (r_pos),
            .o_link  (w_link[k+1]),
            .o_done  (w_done[k])
        );
    end

    // Collect the finishing cell; at most one cell is active at a time.
    // The tail link never carries a live window, but drain it like a finish.
    always_comb begin
        w_fin_any = w_link[STEPS].act;
        w_fin_lo  = w_link[STEPS].act ? w_link[STEPS].lo : '0;
        for (int k = 0; k < STEPS; k++) begin
            w_fin_any = w_fin_any | w_done[k].done;
            w_fin_lo  = w_fin_lo | (w_done[k].done ? w_done[k].lo : '0);
        end
    end

    // Boundary read address: last boundary while idle, else the
    // midpoint of whichever window is being handed to the next cell.
    always_comb begin
        logic [CW-1:0] last;
        logic [CW-1:0] mid_k;
        last    = r_count - {{(CW-1){1'b0}}, 1'b1};
        w_baddr = '0;
        for (int k = 0; k < STEPS; k++) begin
            mid_k   = w_link[k].act ? itl_mid(w_link[k].lo, w_link[k].hi) : {CW{1'b0}};
            w_baddr = w_baddr | mid_k[AW-1:0];
        end
        if (r_state == ST_IDLE) begin
            w_baddr = last[AW-1:0];
        end
    end

    assign w_vaddr = (r_state == ST_SEARCH) ? w_fin_lo[AW-1:0] : '0;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_res     = r_res;
        w_produce = 1'b0;
        w_res     = '0;
        w_we      = 1'b0;
        w_waddr   = r_count[AW-1:0];
        w_head    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.mode == MODE_LOAD) begin
                        if (i_in_data.load_start) begin
                            w_we    = 1'b1;
                            w_waddr = '0;
                            n_count = {{(CW-1){1'b0}}, 1'b1};
                        end else if (r_count < CW'(ENTRIES)) begin
                            w_we    = 1'b1;
                            n_count = r_count + {{(CW-1){1'b0}}, 1'b1};
                        end else begin
                            // full table: drop the entry and flag it
                            w_produce           = 1'b1;
                            w_res.load_overflow = 1'b1;
                        end
                    end else if (r_count == '0) begin
                        w_produce        = 1'b1;
                        w_res.beyond_end = 1'b1;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_pos >= w_bnd) begin
                    w_produce        = 1'b1;
                    w_res.beyond_end = 1'b1;
                end else if (r_count == {{(CW-1){1'b0}}, 1'b1}) begin
                    n_state = ST_VALUE;
                end else begin
                    w_head  = '{act: 1'b1, lo: '0, hi: r_count};
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_fin_any) begin
                    n_state = ST_VALUE;
                end
            end
            ST_VALUE: begin
                w_produce          = 1'b1;
                w_res.mapped_value = w_val;
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Hand a fresh result to the output register, or park it.
        if (w_produce) begin
            if (w_slot_free) begin
                n_state = ST_IDLE;
            end else begin
                n_res   = w_res;
                n_state = ST_EMIT;
            end
        end
    end

    assign w_load_out = (w_produce && w_slot_free) || ((r_state == ST_EMIT) && w_slot_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_res <= n_res;
        if (w_accept) begin
            r_pos <= i_in_data.position;
        end
        if (w_load_out) begin
            r_out <= (r_state == ST_EMIT) ? r_res : w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/itl_checker.sv
module itl_checker
    import itl_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // the two flags never come together
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.beyond_end && o_out_data.load_overflow))
        else $error("beyond_end and load_overflow both set");

    // any flagged result carries a zero value
    a_flag_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.beyond_end || o_out_data.load_overflow)
            |-> o_out_data.mapped_value == '0)
        else $error("flagged result with nonzero value");

endmodule

bind interval_table_lookup_top itl_checker u_itl_checker (.*);
